// ===== rtl/core/smx_pkg.sv =====
`default_nettype none
package smx_pkg;

   localparam int MaxRowDefault = 64;
   localparam int ExpEntries = 1024;
   localparam int ExpIdxW = 10;
   localparam int DotW = 38;
   localparam int QuoW = 17;

   typedef logic [15:0] exp_rom_type [ExpEntries];

   typedef struct packed {
      logic accept;
      logic rd;
      logic rom;
      logic sum_acc;
      logic div_start;
      logic div_step;
      logic mul;
      logic emit;
      logic last;
      logic row_clear;
   } smx_cmd_type;

   typedef struct packed {
      logic mode;
      logic div_done;
      logic out_free;
   } smx_status_type;

   // Bit-serial unsigned division, used only while the table is built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Table of round(65535 * exp(-k/64)), built from a Q62 power series.
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] term;
      logic [63:0] r;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] t;
      term = 64'd1 << 62;
      r = 64'd1 << 62;
      p = 64'd1 << 62;
      for (int n = 1; n <= 24; n++) begin
         term = udiv64(term, 64'(64 * n));
         if ((n % 2) == 1) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      for (int k = 0; k < ExpEntries; k++) begin
         q = p >> 22;
         t = (q * 64'd65535 + (64'd1 << 39)) >> 40;
         rom[k] = t[15:0];
         p = mul_q62(p, r);
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/smx_ram.sv =====
`default_nettype none
module smx_ram #(
   parameter int Width = 32,
   parameter int Depth = 64,
   parameter int AddrW = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/smx_ctrl.sv =====
`default_nettype none
module smx_ctrl #(
   parameter int AddrW = 6,
   parameter int CntW = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_row_end,
   output logic                        req_ready,
   input  wire logic [CntW-1:0]        count,
   input  wire smx_pkg::smx_status_type status,
   output smx_pkg::smx_cmd_type        cmd,
   output logic      [AddrW-1:0]       idx
);
   import smx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD, ST_EXP, ST_ACC, ST_DIVS, ST_DIVW, ST_MUL, ST_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [AddrW-1:0] idx_ff, idx_in;
   logic            pass_ff, pass_in;
   logic            is_last;
   logic            accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign is_last = ((CntW'(idx_ff) + CntW'(1)) == count);
   assign idx = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      pass_in = pass_ff;
      cmd = '0;
      cmd.last = is_last;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept && req_row_end) begin
               idx_in = '0;
               pass_in = 1'b0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd = 1'b1;
            state_in = status.mode ? ST_MUL : ST_EXP;
         end
         ST_EXP: begin
            cmd.rom = 1'b1;
            state_in = pass_ff ? ST_DIVS : ST_ACC;
         end
         ST_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in = ST_RD;
            if (is_last) begin
               idx_in = '0;
               pass_in = 1'b1;
            end else begin
               idx_in = idx_ff + AddrW'(1);
            end
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (is_last) begin
                  cmd.row_clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + AddrW'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         pass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         pass_ff <= pass_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/smx_dpath.sv =====
`default_nettype none
module smx_dpath #(
   parameter int MaxRow = smx_pkg::MaxRowDefault,
   parameter int AddrW = 6,
   parameter int CntW = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_cmd,
   input  wire logic signed [15:0]   req_value,
   input  wire logic        [15:0]   req_soft_value,
   input  wire smx_pkg::smx_cmd_type cmd,
   input  wire logic [AddrW-1:0]     idx,
   output smx_pkg::smx_status_type   status,
   output logic [CntW-1:0]           count,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic        [15:0]        rsp_probability,
   output logic signed [15:0]        rsp_grad_in,
   output logic                      rsp_too_long,
   output logic                      rsp_last
);
   import smx_pkg::*;

   localparam int SumW = $clog2(MaxRow) + 16;
   localparam exp_rom_type ExpRom = build_exp_rom();

   logic [CntW-1:0]          count_ff;
   logic                     mode_ff;
   logic                     ovf_ff;
   logic signed [15:0]       max_ff;
   logic signed [DotW-1:0]   dot_ff;
   logic [SumW-1:0]          sum_ff;
   logic [15:0]              rom_q_ff;
   logic [SumW:0]            rem_ff;
   logic [16:0]              num_ff;
   logic [QuoW-1:0]          quo_ff;
   logic [4:0]               step_ff;
   logic signed [55:0]       v_ff;
   logic                     rsp_valid_ff;
   logic [15:0]              prob_ff;
   logic signed [15:0]       grad_ff;
   logic                     too_long_ff;
   logic                     last_ff;

   logic                     mode_eff;
   logic                     room;
   logic [31:0]              ram_rd;
   logic signed [15:0]       ram_g;
   logic [15:0]              ram_s;
   logic signed [16:0]       diff;
   logic signed [32:0]       prod_in;
   logic [SumW:0]            rem_sh;
   logic signed [38:0]       bw_diff;
   logic signed [55:0]       v_round;
   logic signed [23:0]       r_val;
   logic signed [15:0]       grad_sat;
   logic [15:0]              prob_sat;
   logic                     out_free;

   assign room = (count_ff < CntW'(MaxRow));
   assign mode_eff = (count_ff == '0 && !ovf_ff) ? req_cmd : mode_ff;

   smx_ram #(.Width(32), .Depth(MaxRow), .AddrW(AddrW)) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && room),
      .wr_addr (count_ff[AddrW-1:0]),
      .wr_data ({req_value, req_soft_value}),
      .rd_en   (cmd.rd),
      .rd_addr (idx),
      .rd_data (ram_rd)
   );

   assign ram_g = $signed(ram_rd[31:16]);
   assign ram_s = ram_rd[15:0];
   assign diff = 17'(max_ff) - 17'(ram_g);
   assign prod_in = $signed({1'b0, req_soft_value}) * 33'(req_value);
   assign rem_sh = {rem_ff[SumW-1:0], num_ff[16]};
   assign bw_diff = {{7{ram_g[15]}}, ram_g, 16'd0} - 39'(dot_ff);

   // Round half up, then saturate to Q4.12.
   assign v_round = v_ff + 56'sd2147483648;
   assign r_val = v_round[55:32];
   always_comb begin
      if (r_val > 24'sd32767) begin
         grad_sat = 16'sh7fff;
      end else if (r_val < -24'sd32768) begin
         grad_sat = 16'sh8000;
      end else begin
         grad_sat = r_val[15:0];
      end
   end
   assign prob_sat = quo_ff[16] ? 16'hffff : quo_ff[15:0];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign status.mode = mode_ff;
   assign status.div_done = (step_ff == 5'(QuoW));
   assign status.out_free = out_free;
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff <= 1'b0;
         ovf_ff <= 1'b0;
         max_ff <= '0;
         dot_ff <= '0;
         sum_ff <= '0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            mode_ff <= mode_eff;
            if (room) begin
               count_ff <= count_ff + CntW'(1);
               if (!mode_eff) begin
                  if (count_ff == '0 || req_value > max_ff) begin
                     max_ff <= req_value;
                  end
               end else begin
                  dot_ff <= dot_ff + DotW'(prod_in);
               end
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.sum_acc) begin
            sum_ff <= sum_ff + SumW'(rom_q_ff);
         end
         if (cmd.div_start) begin
            step_ff <= '0;
         end else if (cmd.div_step) begin
            step_ff <= step_ff + 5'd1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.row_clear) begin
            count_ff <= '0;
            mode_ff <= 1'b0;
            ovf_ff <= 1'b0;
            max_ff <= '0;
            dot_ff <= '0;
            sum_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rom) begin
         rom_q_ff <= ExpRom[diff[15:6]];
      end
      // The quotient fits in 17 bits, so the top 15 numerator bits seed the remainder.
      if (cmd.div_start) begin
         rem_ff <= (SumW+1)'(rom_q_ff[15:1]);
         num_ff <= {rom_q_ff[0], 16'd0};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[15:0], 1'b0};
         if (rem_sh >= (SumW+1)'(sum_ff)) begin
            rem_ff <= rem_sh - (SumW+1)'(sum_ff);
            quo_ff <= {quo_ff[QuoW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QuoW-2:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         v_ff <= 56'($signed({1'b0, ram_s}) * bw_diff);
      end
      if (cmd.emit) begin
         prob_ff <= mode_ff ? 16'd0 : prob_sat;
         grad_ff <= mode_ff ? grad_sat : 16'sd0;
         too_long_ff <= ovf_ff;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_probability = prob_ff;
   assign rsp_grad_in = grad_ff;
   assign rsp_too_long = too_long_ff;
   assign rsp_last = last_ff;
endmodule
`default_nettype wire

// ===== rtl/core/softmax_row_forward_backward_unit.sv =====
`default_nettype none
// A non-final transaction is written to the row RAM when accepted. After the final one, a
// forward row runs a sum pass (read, table lookup, accumulate per element), then reads each
// element again for a table lookup and the 17-step serial divider; a backward row reads,
// multiplies and emits each element. The shared divider sets the pace in forward mode.
// Reset (synchronous, active high) clears the row counters, max, dot product and handshakes.
module softmax_row_forward_backward_unit #(
   parameter int MaxRow = smx_pkg::MaxRowDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic signed [15:0] req_value,
   input  wire logic        [15:0] req_soft_value,
   input  wire logic               req_row_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic        [15:0]      rsp_probability,
   output logic signed [15:0]      rsp_grad_in,
   output logic                    rsp_too_long,
   output logic                    rsp_last
);
   import smx_pkg::*;

   localparam int AddrW = (MaxRow > 1) ? $clog2(MaxRow) : 1;
   localparam int CntW = $clog2(MaxRow + 1);

   smx_cmd_type    cmd;
   smx_status_type status;
   logic [AddrW-1:0] idx;
   logic [CntW-1:0]  count;

   smx_ctrl #(.AddrW(AddrW), .CntW(CntW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_row_end (req_row_end),
      .req_ready   (req_ready),
      .count       (count),
      .status      (status),
      .cmd         (cmd),
      .idx         (idx)
   );

   smx_dpath #(.MaxRow(MaxRow), .AddrW(AddrW), .CntW(CntW)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_soft_value  (req_soft_value),
      .cmd             (cmd),
      .idx             (idx),
      .status          (status),
      .count           (count),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_probability (rsp_probability),
      .rsp_grad_in     (rsp_grad_in),
      .rsp_too_long    (rsp_too_long),
      .rsp_last        (rsp_last)
   );
endmodule
`default_nettype wire
